// File: src/modexp_pkg.sv
// Package: shared constants and types for the modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none
package modexp_pkg;
  localparam int unsigned WordBits = 64;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_SQR    = 6'b001000,
    ST_NEXT   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;
endpackage
`default_nettype wire

// File: src/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply modular exponentiation.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time; busy is high from the transfer through the result cycle.
// The base is first reduced modulo m. Each of the WORD_BITS exponent
// bits then costs one square and, when set, one multiply on a single bit-serial
// modular multiplier, plus a pass through the ST_NEXT bookkeeping state.
// A zero modulus or zero exponent goes straight to ST_DONE. The result appears for
// one cycle with done_o high and must be taken then; it cannot be held off.
module modular_exponentiation #(
  parameter int unsigned WORD_BITS = modexp_pkg::WordBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [WORD_BITS-1:0] base_value_i,
  input  wire logic [WORD_BITS-1:0] exponent_i,
  input  wire logic [WORD_BITS-1:0] modulus_value_i,
  output logic                      done_o,
  output logic [WORD_BITS-1:0]      power_result_o,
  output logic                      modulus_error_o
);
  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  modexp_pkg::state_e   state_q, state_d;
  logic [WORD_BITS-1:0] b_q, b_d, e_q, e_d, m_q, r_q, r_d, res_q, res_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 err_q, err_d, done_q, done_d;
  logic                 red_start, red_done, mul_start, mul_done;
  logic [WORD_BITS-1:0] red_r, mul_x, mul_y, mul_p;
  logic                 take;

  assign take = start && !busy;

  modexp_reduce #(.WORD_BITS(WORD_BITS)) u_reduce (
    .clk_i, .rst_ni, .start_i(red_start), .a_i(base_value_i),
    .m_i(modulus_value_i), .done_o(red_done), .r_o(red_r)
  );

  modexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mulmod (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(mul_x), .y_i(mul_y),
    .m_i(m_q), .done_o(mul_done), .p_o(mul_p)
  );

  assign red_start = take && (modulus_value_i != '0) && (exponent_i != '0);

  always_comb begin
    state_d   = state_q;
    b_d       = b_q;
    e_d       = e_q;
    r_d       = r_q;
    res_d     = res_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    done_d    = 1'b0;
    mul_start = 1'b0;
    mul_x     = r_q;
    mul_y     = b_q;
    unique case (state_q)
      modexp_pkg::ST_IDLE: begin
        if (take) begin
          e_d   = exponent_i;
          r_d   = WORD_BITS'(1);
          cnt_d = CntW'(WORD_BITS);
          if (modulus_value_i == '0) begin
            res_d   = '0;
            err_d   = 1'b1;
            state_d = modexp_pkg::ST_DONE;
          end else if (exponent_i == '0) begin
            res_d   = WORD_BITS'(1);
            err_d   = 1'b0;
            state_d = modexp_pkg::ST_DONE;
          end else begin
            err_d   = 1'b0;
            state_d = modexp_pkg::ST_REDUCE;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (red_done) begin
          b_d = red_r;
          // r = 1 mod m; with m == 1 this is 0.
          r_d = (m_q == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
          state_d = modexp_pkg::ST_NEXT;
        end
      end
      modexp_pkg::ST_NEXT: begin
        if (cnt_q == '0) begin
          res_d   = r_q;
          state_d = modexp_pkg::ST_DONE;
        end else if (e_q[0]) begin
          mul_start = 1'b1;
          state_d   = modexp_pkg::ST_MUL;
        end else begin
          mul_start = 1'b1;
          mul_x     = b_q;
          state_d   = modexp_pkg::ST_SQR;
        end
      end
      modexp_pkg::ST_MUL: begin
        if (mul_done) begin
          r_d       = mul_p;
          mul_start = 1'b1;
          mul_x     = b_q;
          state_d   = modexp_pkg::ST_SQR;
        end
      end
      modexp_pkg::ST_SQR: begin
        if (mul_done) begin
          b_d     = mul_p;
          e_d     = {1'b0, e_q[WORD_BITS-1:1]};
          cnt_d   = cnt_q - 1'b1;
          state_d = modexp_pkg::ST_NEXT;
        end
      end
      modexp_pkg::ST_DONE: begin
        done_d  = 1'b1;
        state_d = modexp_pkg::ST_IDLE;
      end
      default: state_d = modexp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= modexp_pkg::ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    e_q   <= e_d;
    r_q   <= r_d;
    res_q <= res_d;
    err_q <= err_d;
    if (take) begin
      m_q <= modulus_value_i;
    end
  end

  assign busy            = (state_q != modexp_pkg::ST_IDLE) || done_q;
  assign done_o          = done_q;
  assign power_result_o  = res_q;
  assign modulus_error_o = err_q;
endmodule
`default_nettype wire

// File: src/modexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module modexp_mulmod #(
  parameter int unsigned WORD_BITS = modexp_pkg::WordBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WORD_BITS-1:0] x_i,
  input  wire logic [WORD_BITS-1:0] y_i,
  input  wire logic [WORD_BITS-1:0] m_i,
  output logic                      done_o,
  output logic [WORD_BITS-1:0]      p_o
);
  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] acc_q, acc_d, y_q, y_d, x_q, m_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 run_q, run_d, done_q, done_d;
  logic [WORD_BITS:0]   dbl, dbl_r, sum;
  logic [WORD_BITS-1:0] acc2;

  // Operands are already reduced below m; double then conditionally add.
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    acc2  = dbl_r[WORD_BITS-1:0];
    sum   = {1'b0, acc2} + {1'b0, x_q};
    if (y_q[WORD_BITS-1]) begin
      sum = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
    end else begin
      sum = {1'b0, acc2};
    end
  end

  always_comb begin
    acc_d  = acc_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      y_d   = y_i;
      cnt_d = CntW'(WORD_BITS);
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = sum[WORD_BITS-1:0];
      y_d   = {y_q[WORD_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    y_q   <= y_d;
    if (start_i) begin
      x_q <= x_i;
      m_q <= m_i;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule
`default_nettype wire

// File: src/modexp_reduce.sv
// Bit-serial reducer: base mod m by restoring long division, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module modexp_reduce #(
  parameter int unsigned WORD_BITS = modexp_pkg::WordBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WORD_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] m_i,
  output logic                      done_o,
  output logic [WORD_BITS-1:0]      r_o
);
  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] rem_q, rem_d, a_q, a_d, m_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 run_q, run_d, done_q, done_d;
  logic [WORD_BITS:0]   sh;

  always_comb begin
    sh     = {rem_q, a_q[WORD_BITS-1]};
    rem_d  = rem_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      a_d   = a_i;
      cnt_d = CntW'(WORD_BITS);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = (sh >= {1'b0, m_q}) ? WORD_BITS'(sh - {1'b0, m_q}) : sh[WORD_BITS-1:0];
      a_d   = {a_q[WORD_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    a_q   <= a_d;
    if (start_i) begin
      m_q <= m_i;
    end
  end

  assign done_o = done_q;
  assign r_o    = rem_q;
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench: random and directed checks of the 64-bit modular exponentiation block.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned W = modexp_pkg::WordBits;
  localparam longint unsigned CycleLimit = 64'd30_000_000;

  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] expo;
    logic [W-1:0] modulus;
  } operands_t;

  typedef struct packed {
    logic [W-1:0] power;
    logic         err;
  } power_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] base_value_i = '0;
  logic [W-1:0] exponent_i = '0;
  logic [W-1:0] modulus_value_i = '0;
  logic         done_o;
  logic [W-1:0] power_result_o;
  logic         modulus_error_o;

  operands_t pending_ops[$];
  power_t    expected_powers[$];
  int unsigned gap_left = 0;
  int unsigned quiet_left = 0;
  longint unsigned cycle_count = 0;
  bit failed = 1'b0;

  modular_exponentiation DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .base_value_i(base_value_i), .exponent_i(exponent_i),
    .modulus_value_i(modulus_value_i), .done_o(done_o),
    .power_result_o(power_result_o), .modulus_error_o(modulus_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [W-1:0] mul_reduce(logic [W-1:0] a, logic [W-1:0] b,
                                              logic [W-1:0] m);
    logic [2*W-1:0] prod;
    prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(prod % {{W{1'b0}}, m});
  endfunction

  function automatic power_t modpow(operands_t op);
    power_t res;
    logic [W-1:0] b;
    logic [W-1:0] r;
    res = '0;
    if (op.modulus == '0) begin
      res.err = 1'b1;
      return res;
    end
    b = op.base % op.modulus;
    r = W'(1);
    for (int i = 0; i < W; i++) begin
      if (op.expo[i]) r = mul_reduce(r, b, op.modulus);
      b = mul_reduce(b, b, op.modulus);
    end
    res.power = r;
    return res;
  endfunction

  function automatic logic [W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Driver: hold start until the transfer, then advance to the next item.
  always @(posedge clk_i) begin
    logic      accepted;
    operands_t cur;
    if (rst_ni) begin
      accepted = start && !busy;
      if (accepted) begin
        cur = '{base: base_value_i, expo: exponent_i, modulus: modulus_value_i};
        expected_powers.push_back(modpow(cur));
        void'(pending_ops.pop_front());
        if (quiet_left > 0) begin
          quiet_left--;
          gap_left = 0;
        end else begin
          gap_left = draw_gap();
          if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(5, 30);
        end
      end
      if (start && !accepted) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        start <= 1'b1;
        base_value_i <= pending_ops[0].base;
        exponent_i <= pending_ops[0].expo;
        modulus_value_i <= pending_ops[0].modulus;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result against the oldest expectation.
  always @(posedge clk_i) begin
    power_t want;
    if (rst_ni && done_o) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result power=%h err=%b", $time, power_result_o,
                 modulus_error_o);
        failed = 1'b1;
      end else begin
        want = expected_powers.pop_front();
        if (power_result_o !== want.power) begin
          $display("%0t: power_result expected %h actual %h", $time, want.power,
                   power_result_o);
          failed = 1'b1;
        end
        if (modulus_error_o !== want.err) begin
          $display("%0t: modulus_error expected %b actual %b", $time, want.err,
                   modulus_error_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_item(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
    pending_ops.push_back('{base: b, expo: e, modulus: m});
  endtask

  initial begin
    logic [W-1:0] m;
    logic [W-1:0] e;
    int unsigned kind;
    logic [W-1:0] ones;
    ones = '1;
    add_item(W'(5), W'(3), W'(0));
    add_item(ones, ones, W'(0));
    add_item(W'(7), W'(0), W'(13));
    add_item(W'(7), W'(0), W'(1));
    add_item(ones, W'(0), ones);
    add_item(W'(9), W'(5), W'(1));
    add_item(ones, ones, W'(1));
    add_item(ones, ones, ones);
    add_item(ones, W'(2), ones - W'(1));
    add_item(W'(0), W'(5), W'(97));
    add_item(W'(0), W'(0), W'(97));
    add_item(W'(2), W'(10), W'(1000));
    add_item(W'(3), ones, 64'hFFFF_FFFF_FFFF_FFC5);
    add_item(ones - W'(1), ones, 64'h8000_0000_0000_0000);
    add_item(64'h8000_0000_0000_0001, W'(1), 64'h7FFF_FFFF_FFFF_FFFF);
    add_item(W'(97), W'(1), W'(97));
    add_item(ones, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_0000_0001);
    add_item(W'(2), W'(64), W'(3));
    add_item(rand_word(), rand_word(), W'(2));
    add_item(W'(12345), W'(1), ones);
    for (int n = 0; n < 1030; n++) begin
      kind = $urandom_range(0, 9);
      m = rand_word();
      e = rand_word();
      case (kind)
        0: m = W'($urandom_range(0, 3));
        1: m = {1'b1, m[W-2:0]};
        2: m = W'($urandom_range(1, 1000));
        3: e = W'($urandom_range(0, 15));
        4: e = e >> $urandom_range(0, W - 1);
        default: ;
      endcase
      if (kind == 5) add_item(m + W'($urandom_range(0, 3)), e, m);
      else add_item(rand_word(), e, m);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0 && expected_powers.size() == 0);
    repeat (20) @(posedge clk_i);
    if (!failed && expected_powers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
